FILE: src/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants, types and helper functions for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Default number of fraction bits (1.0 == 2**FRAC_BITS)
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int HUE_W = 16;   // hue in whole degrees
  localparam int SV_W  = 18;   // signed saturation / value
  localparam int CH_W  = 17;   // unsigned output channel

  // Hue reduction
  localparam int HUE_RANGE   = 360;
  localparam int SECTOR_SPAN = 60;
  // floor(x / 360) ~= (x * RECIP_360) >> RECIP_SHIFT, low by at most one
  localparam int RECIP_360   = 46603;
  localparam int RECIP_SHIFT = 24;
  localparam int QUOT_W      = 8;    // quotient of a 16-bit hue by 360
  localparam int REM_W       = 10;   // remainder before correction, < 720
  localparam int HMOD_W      = 9;    // hue mod 360
  localparam int FRAC_IDX_W  = 6;    // hue mod 60
  localparam int FRAC_TAB_D  = 1 << FRAC_IDX_W;

  // Pipeline depth
  localparam int NSTAGE = 7;

  // Hue sector, named by the color span it covers
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Per-stage load enables
  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctl_t;

  // Fraction of a sector: (idx << frac) / 60, evaluated at elaboration only
  function automatic longint unsigned fraction_of(int unsigned idx, int unsigned frac);
    longint unsigned num;
    num = longint'(idx) << frac;
    return num / SECTOR_SPAN;
  endfunction

endpackage

FILE: src/hsv2rgb_hue_split.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hue_split
// Hue path: reduce mod 360, split into sector and in-sector fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_split #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  hsv2rgb_pkg::pipe_ctl_t              ctl,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue_degrees,
  output hsv2rgb_pkg::sector_t                sector,
  output logic [FRAC_BITS-1:0]                frac
);

  localparam int HW  = hsv2rgb_pkg::HUE_W;
  localparam int PW  = 2 * HW;
  localparam int RWW = HW + 1;
  localparam int QW  = hsv2rgb_pkg::QUOT_W;
  localparam int RW  = hsv2rgb_pkg::REM_W;
  localparam int MW  = hsv2rgb_pkg::HMOD_W;
  localparam int IW  = hsv2rgb_pkg::FRAC_IDX_W;
  localparam int SP  = hsv2rgb_pkg::SECTOR_SPAN;

  // sector fraction table
  logic [FRAC_BITS-1:0] frac_tab [hsv2rgb_pkg::FRAC_TAB_D];

  for (genvar g = 0; g < hsv2rgb_pkg::FRAC_TAB_D; g++) begin : g_tab
    assign frac_tab[g] = FRAC_BITS'(hsv2rgb_pkg::fraction_of(g, FRAC_BITS));
  end

  // stage 0: reciprocal estimate of hue / 360
  logic [PW-1:0]  recip_prod;
  logic [HW-1:0]  hue0_r;
  logic [QW-1:0]  quot0_nxt, quot0_r;

  assign recip_prod = PW'(hue_degrees) * PW'(hsv2rgb_pkg::RECIP_360);
  assign quot0_nxt  = recip_prod[hsv2rgb_pkg::RECIP_SHIFT +: QW];

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      hue0_r  <= hue_degrees;
      quot0_r <= quot0_nxt;
    end
  end

  // stage 1: remainder with a single correction step
  logic [RWW-1:0] rem_wide;
  logic [RW-1:0]  rem;
  logic [MW-1:0]  hmod1_nxt, hmod1_r;

  assign rem_wide  = RWW'(hue0_r) - RWW'(quot0_r) * RWW'(hsv2rgb_pkg::HUE_RANGE);
  assign rem       = rem_wide[RW-1:0];
  assign hmod1_nxt = (rem >= RW'(hsv2rgb_pkg::HUE_RANGE))
                   ? MW'(rem - RW'(hsv2rgb_pkg::HUE_RANGE)) : rem[MW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      hmod1_r <= hmod1_nxt;
    end
  end

  // stage 2: sector and offset inside it
  hsv2rgb_pkg::sector_t sec2_nxt, sec2_r;
  logic [MW-1:0]        base2;
  logic [IW-1:0]        idx2_nxt, idx2_r;

  always_comb begin
    if (hmod1_r >= MW'(5 * SP)) begin
      sec2_nxt = hsv2rgb_pkg::SEC_MAG_RED;
      base2    = MW'(5 * SP);
    end else if (hmod1_r >= MW'(4 * SP)) begin
      sec2_nxt = hsv2rgb_pkg::SEC_BLU_MAG;
      base2    = MW'(4 * SP);
    end else if (hmod1_r >= MW'(3 * SP)) begin
      sec2_nxt = hsv2rgb_pkg::SEC_CYN_BLU;
      base2    = MW'(3 * SP);
    end else if (hmod1_r >= MW'(2 * SP)) begin
      sec2_nxt = hsv2rgb_pkg::SEC_GRN_CYN;
      base2    = MW'(2 * SP);
    end else if (hmod1_r >= MW'(SP)) begin
      sec2_nxt = hsv2rgb_pkg::SEC_YEL_GRN;
      base2    = MW'(SP);
    end else begin
      sec2_nxt = hsv2rgb_pkg::SEC_RED_YEL;
      base2    = '0;
    end
  end

  assign idx2_nxt = IW'(hmod1_r - base2);

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      sec2_r <= sec2_nxt;
      idx2_r <= idx2_nxt;
    end
  end

  // stage 3: fraction lookup
  hsv2rgb_pkg::sector_t sec3_r;
  logic [FRAC_BITS-1:0] frac3_r;

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      sec3_r  <= sec2_r;
      frac3_r <= frac_tab[idx2_r];
    end
  end

  assign sector = sec3_r;
  assign frac   = frac3_r;

endmodule

FILE: src/hsv2rgb_shade.sv
// ----------------------------------------------------------------------------
// hsv2rgb_shade
// Saturation/value path: clamp, form p, q, t and pick the RGB triple.
// ----------------------------------------------------------------------------
module hsv2rgb_shade #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  hsv2rgb_pkg::pipe_ctl_t                  ctl,
  input  logic signed [hsv2rgb_pkg::SV_W-1:0]     saturation,
  input  logic signed [hsv2rgb_pkg::SV_W-1:0]     brightness,
  input  hsv2rgb_pkg::sector_t                    sector,    // stage 3 timing
  input  logic [FRAC_BITS-1:0]                    frac,      // stage 3 timing
  output logic [hsv2rgb_pkg::CH_W-1:0]            red,
  output logic [hsv2rgb_pkg::CH_W-1:0]            green,
  output logic [hsv2rgb_pkg::CH_W-1:0]            blue
);

  localparam int SW = hsv2rgb_pkg::SV_W;
  localparam int OW = hsv2rgb_pkg::CH_W;
  localparam int UW = FRAC_BITS + 1;               // holds 0..ONE
  localparam int CW = (SW - 1 > UW) ? SW - 1 : UW; // clamp compare width
  localparam int PW = 2 * UW;
  localparam logic [UW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [UW-1:0] clamp_unit(logic signed [SW-1:0] raw);
    logic [CW-1:0] mag;
    mag = CW'(raw[SW-2:0]);
    if (raw[SW-1]) begin
      return '0;
    end else if (mag > CW'(ONE)) begin
      return ONE;
    end
    return UW'(mag);
  endfunction

  // truncating fixed-point product
  function automatic logic [UW-1:0] fix_mul(logic [UW-1:0] a, logic [UW-1:0] b);
    logic [PW-1:0] prod;
    prod = PW'(a) * PW'(b);
    return prod[FRAC_BITS +: UW];
  endfunction

  // stages 0..2: clamp, then wait for the hue path
  logic [UW-1:0] sat_r [3];
  logic [UW-1:0] val_r [3];

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      sat_r[0] <= clamp_unit(saturation);
      val_r[0] <= clamp_unit(brightness);
    end
    if (ctl.en[1]) begin
      sat_r[1] <= sat_r[0];
      val_r[1] <= val_r[0];
    end
    if (ctl.en[2]) begin
      sat_r[2] <= sat_r[1];
      val_r[2] <= val_r[1];
    end
  end

  // stage 3: p = v * (1 - s)
  logic [UW-1:0] p3_nxt, p3_r, sat3_r, val3_r;

  assign p3_nxt = fix_mul(val_r[2], ONE - sat_r[2]);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      p3_r   <= p3_nxt;
      sat3_r <= sat_r[2];
      val3_r <= val_r[2];
    end
  end

  // stage 4: s * f and s * (1 - f)
  logic [UW-1:0] sf4_nxt, sg4_nxt, sf4_r, sg4_r, p4_r, val4_r;
  hsv2rgb_pkg::sector_t sec4_r;

  assign sf4_nxt = fix_mul(sat3_r, UW'(frac));
  assign sg4_nxt = fix_mul(sat3_r, ONE - UW'(frac));

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      sf4_r  <= sf4_nxt;
      sg4_r  <= sg4_nxt;
      p4_r   <= p3_r;
      val4_r <= val3_r;
      sec4_r <= sector;
    end
  end

  // stage 5: q and t
  logic [UW-1:0] q5_nxt, t5_nxt, q5_r, t5_r, p5_r, val5_r;
  hsv2rgb_pkg::sector_t sec5_r;

  assign q5_nxt = fix_mul(val4_r, ONE - sf4_r);
  assign t5_nxt = fix_mul(val4_r, ONE - sg4_r);

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      q5_r   <= q5_nxt;
      t5_r   <= t5_nxt;
      p5_r   <= p4_r;
      val5_r <= val4_r;
      sec5_r <= sec4_r;
    end
  end

  // stage 6: sector select (zero saturation falls out as v, v, v)
  logic [UW-1:0] r6_sel, g6_sel, b6_sel;
  logic [OW-1:0] red_r, green_r, blue_r;

  always_comb begin
    unique case (sec5_r)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        r6_sel = val5_r; g6_sel = t5_r;   b6_sel = p5_r;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        r6_sel = q5_r;   g6_sel = val5_r; b6_sel = p5_r;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        r6_sel = p5_r;   g6_sel = val5_r; b6_sel = t5_r;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        r6_sel = p5_r;   g6_sel = q5_r;   b6_sel = val5_r;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        r6_sel = t5_r;   g6_sel = p5_r;   b6_sel = val5_r;
      end
      default: begin
        r6_sel = val5_r; g6_sel = p5_r;   b6_sel = q5_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      red_r   <= OW'(r6_sel);
      green_r <= OW'(g6_sel);
      blue_r  <= OW'(b6_sel);
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

FILE: src/hsv_to_rgb_convert_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_core
// Streaming HSV to RGB color converter, seven-stage pipeline, no state.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                                  | Handshake
//  --------+-----------+------------------------------------------+------------------
//  in_     | slave     | tdata: hue 16b, saturation 18b, value 18b | tvalid / tready
//  out_    | master    | tdata: red 17b, green 17b, blue 17b       | tvalid / tready
//
// Cycles: one transaction per clock sustained while out_tready is high; a
//   result passes through seven register stages, set by the hue reduction,
//   the fraction lookup, two dependent multiply levels and the sector select.
// Reset: rst_n (synchronous, active low) clears the stage valid bits only.
// Stalls: each stage loads when it is empty or the stage after it moves, so
//   bubbles are squeezed out and, while any stage is empty, input is still
//   taken while a result waits at the output; nothing is dropped or repeated.
//
module hsv_to_rgb_convert_core #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [15:0] hue_degrees, [33:16] saturation,
                                  // [51:34] brightness, [55:52] zero
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [16:0] red, [33:17] green, [50:34] blue,
                                  // [55:51] zero
);

  localparam int NS = hsv2rgb_pkg::NSTAGE;
  localparam int HW = hsv2rgb_pkg::HUE_W;
  localparam int SW = hsv2rgb_pkg::SV_W;
  localparam int OW = hsv2rgb_pkg::CH_W;

  // --------------------------------------------------------------------------
  // Pipeline control: valid bit per stage, enable ripples back from the output
  // --------------------------------------------------------------------------
  logic [NS-1:0]          vld_r;
  logic [NS-1:0]          vld_nxt;
  hsv2rgb_pkg::pipe_ctl_t ctl;

  always_comb begin
    ctl.en[NS-1] = !vld_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      ctl.en[k] = !vld_r[k] || ctl.en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.en[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < NS; k++) begin
      if (ctl.en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = ctl.en[0];
  assign out_tvalid = vld_r[NS-1];

  // --------------------------------------------------------------------------
  // Payload unpack
  // --------------------------------------------------------------------------
  logic [HW-1:0]        hue_degrees;
  logic signed [SW-1:0] saturation;
  logic signed [SW-1:0] brightness;

  assign hue_degrees = in_tdata[HW-1:0];
  assign saturation  = in_tdata[HW +: SW];
  assign brightness  = in_tdata[HW+SW +: SW];

  // --------------------------------------------------------------------------
  // Hue path (stages 0..3) and shade path (stages 0..6)
  // --------------------------------------------------------------------------
  hsv2rgb_pkg::sector_t sector;
  logic [FRAC_BITS-1:0] frac;
  logic [OW-1:0]        red, green, blue;

  hsv2rgb_hue_split #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hue (
    .clk         (clk),
    .ctl         (ctl),
    .hue_degrees (hue_degrees),
    .sector      (sector),
    .frac        (frac)
  );

  hsv2rgb_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade (
    .clk        (clk),
    .ctl        (ctl),
    .saturation (saturation),
    .brightness (brightness),
    .sector     (sector),
    .frac       (frac),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  assign out_tdata = {5'd0, blue, green, red};

endmodule
